// ===== hw/rtl/grc_pkg.sv =====
// Shared types and constants of the glyph readability check.
// Holds the sequencer state type, verdict codes and register indexes.
// Depends on nothing.
`timescale 1ns / 1ps

package grc_pkg;

   localparam int PIXEL_W   = 8;
   localparam int BBOX_W    = 9;
   localparam int VERDICT_W = 3;
   localparam int COUNT_W   = 9;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   // Register indexes on the configuration channel.
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GLYPH_SIDE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RATIO  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_OFS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SMALL_STEP = 3'd4;

   // Verdict codes of a result.
   localparam logic [VERDICT_W-1:0] VERDICT_DISABLED   = 3'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_LARGE_FONT = 3'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_SMALL_BBOX = 3'd2;
   localparam logic [VERDICT_W-1:0] VERDICT_CORE_COUNT = 3'd3;
   localparam logic [VERDICT_W-1:0] VERDICT_CORE_DEPTH = 3'd4;
   localparam logic [VERDICT_W-1:0] VERDICT_READABLE   = 3'd5;

   // Sequencer states.
   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_PREP   = 14'b00000000000010,
      ST_CHECK  = 14'b00000000000100,
      ST_BRD    = 14'b00000000001000,
      ST_BACC   = 14'b00000000010000,
      ST_BTHR   = 14'b00000000100000,
      ST_BCMP   = 14'b00000001000000,
      ST_DINIT  = 14'b00000010000000,
      ST_DSELF  = 14'b00000100000000,
      ST_DRD    = 14'b00001000000000,
      ST_DACC   = 14'b00010000000000,
      ST_DEVAL  = 14'b00100000000000,
      ST_DECIDE = 14'b01000000000000,
      ST_FINISH = 14'b10000000000000
   } state_type;

endpackage

// ===== hw/rtl/grc_ram.sv =====
// Simple dual-port memory with one write port and one registered read port.
// Used for the pixel store and the binary store; no dependencies.
`timescale 1ns / 1ps

module grc_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 361
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/glyph_readability_check_top.sv =====
// Top level of the glyph readability check: stream ports, register file,
// sequencer and the shared arithmetic. Uses grc_pkg and grc_ram.
`timescale 1ns / 1ps

// Pixels of a glyph of side S arrive one per cycle in raster order and are
// stored; the pixel marked last starts the decision and yields one result.
// While the decision runs, the input is not ready. Disabled blocks, fonts of
// FONT_SIZE_LIMIT and above, and small bounding boxes skip the binarisation
// and distance passes. Otherwise each pixel is binarised by reading its w*w
// box neighbors (w = 3, or 5 when S > 15) through the single read port of
// the pixel memory, and then each foreground pixel scans the whole binary
// memory for the nearest background pixel; a background pixel skips the
// scan. The binary memory read port serialises this scan. Pixels of the
// next glyph may load while a result waits.

module glyph_readability_check_top #(
   parameter int FONT_SIZE_LIMIT = 20
) (
   input  logic                           clock,
   input  logic                           reset,
   // req_tdata: pixel [7:0], bbox_area [16:8], zero fill above
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [23:0]                    req_tdata,
   input  logic                           req_tlast,
   // rsp_tdata: disposable [0], verdict [3:1], core_count [12:4], zero fill
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [15:0]                    rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [grc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [grc_pkg::CSR_DAT_W-1:0]  csr_data
);

   import grc_pkg::*;

   localparam int MAX_SIDE = FONT_SIZE_LIMIT - 1;
   localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
   localparam int AW       = $clog2(DEPTH);
   localparam int CW       = $clog2(DEPTH + 1);
   localparam int SW       = $clog2(FONT_SIZE_LIMIT);

   // Configuration registers.
   logic        enable_ff, enable_in;
   logic [7:0]  side_ff, side_in;
   logic [15:0] ratio_ff, ratio_in;
   logic [15:0] base_ff, base_in;
   logic [15:0] step_ff, step_in;

   state_type   state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [8:0]  bbox_ff, bbox_in;
   logic [SW-1:0] r_ff, r_in, c_ff, c_in, r2_ff, r2_in, c2_ff, c2_in;
   logic [2:0]  ti_ff, ti_in, tj_ff, tj_in;
   logic [2*SW-1:0] ss_ff, ss_in;
   logic [11:0] sp5_ff, sp5_in;
   logic [28:0] sub_ff, sub_in;
   logic [33:0] nsub_ff, nsub_in;
   logic [12:0] sum_ff, sum_in;
   logic [7:0]  p_ff, p_in;
   logic        inr_ff, inr_in;
   logic [33:0] thr_ff, thr_in;
   logic [28:0] lhs_ff, lhs_in;
   logic [10:0] best_ff, best_in;
   logic [8:0]  count_ff, count_in;
   logic        deep_ff, deep_in;
   logic [2:0]  verd_ff, verd_in;
   logic        disp_ff, disp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;

   // Memory ports.
   logic          g_we, b_we, b_wdata;
   logic [AW-1:0] g_waddr, g_raddr, b_waddr, b_raddr;
   logic [7:0]    g_rdata;
   logic          b_rdata;

   // Derived values.
   logic [SW-1:0]   s_n;
   logic            wide;
   logic [4:0]      n_val;
   logic [SW:0]     h_val;
   logic [2:0]      tap_end;
   logic [SW:0]     rp, cp;
   logic            rin, cin;
   logic [SW-1:0]   rr, cc;
   logic [AW-1:0]   tap_addr, cur_addr, scan_addr;
   logic            row_end, col_end, scan_row_end, scan_col_end;
   logic [SW-1:0]   dr, dc;
   logic [10:0]     sq_dist;
   logic [SW:0]     m_val;
   logic [3:0]      k_val;
   logic            core, over;

   assign s_n     = side_ff[SW-1:0];
   assign wide    = side_ff > 8'd15;
   assign n_val   = wide ? 5'd25 : 5'd9;
   assign h_val   = wide ? (SW+1)'(2) : (SW+1)'(1);
   assign tap_end = wide ? 3'd4 : 3'd2;
   assign k_val   = (side_ff < 8'd15) ? 4'(8'd15 - side_ff) : 4'd0;

   // Box window tap coordinates with padding detection.
   assign rp       = {1'b0, r_ff} + (SW+1)'(ti_ff);
   assign cp       = {1'b0, c_ff} + (SW+1)'(tj_ff);
   assign rin      = (rp >= h_val) && ((rp - h_val) < {1'b0, s_n});
   assign cin      = (cp >= h_val) && ((cp - h_val) < {1'b0, s_n});
   assign rr       = SW'(rp - h_val);
   assign cc       = SW'(cp - h_val);
   assign tap_addr = AW'((2*SW)'(rr) * (2*SW)'(s_n) + (2*SW)'(cc));
   assign cur_addr = AW'((2*SW)'(r_ff) * (2*SW)'(s_n) + (2*SW)'(c_ff));
   assign scan_addr = AW'((2*SW)'(r2_ff) * (2*SW)'(s_n) + (2*SW)'(c2_ff));

   assign col_end      = c_ff == s_n - SW'(1);
   assign row_end      = r_ff == s_n - SW'(1);
   assign scan_col_end = c2_ff == s_n - SW'(1);
   assign scan_row_end = r2_ff == s_n - SW'(1);

   // Squared distance to the scanned pixel.
   assign dr      = (r_ff >= r2_ff) ? r_ff - r2_ff : r2_ff - r_ff;
   assign dc      = (c_ff >= c2_ff) ? c_ff - c2_ff : c2_ff - c_ff;
   assign sq_dist = 11'(10'(dr) * 10'(dr)) + 11'(10'(dc) * 10'(dc));

   // Distance to the zero frame around the glyph.
   always_comb begin
      logic [SW:0] a1, a2, a3, a4;
      a1 = {1'b0, r_ff} + (SW+1)'(1);
      a2 = {1'b0, c_ff} + (SW+1)'(1);
      a3 = {1'b0, s_n} - {1'b0, r_ff};
      a4 = {1'b0, s_n} - {1'b0, c_ff};
      m_val = a1;
      if (a2 < m_val) m_val = a2;
      if (a3 < m_val) m_val = a3;
      if (a4 < m_val) m_val = a4;
   end

   // Depth tests against the allowed shell and the depth limit.
   always_comb begin
      if (side_ff <= 8'd10) begin
         core = (18'(best_ff) * 18'd100) > 18'd361;
         over = (18'(best_ff) * 18'd100) > 18'd841;
      end else begin
         core = (16'(best_ff) * 16'd25) > 16'(ss_ff);
         over = (16'(best_ff) * 16'd25) > 16'(sp5_ff);
      end
   end

   grc_ram #(.DATA_W(8), .DEPTH(DEPTH)) u_glyph_ram (
      .clock   (clock),
      .wr_en   (g_we),
      .wr_addr (g_waddr),
      .wr_data (req_tdata[7:0]),
      .rd_addr (g_raddr),
      .rd_data (g_rdata)
   );

   grc_ram #(.DATA_W(1), .DEPTH(DEPTH)) u_binary_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_waddr),
      .wr_data (b_wdata),
      .rd_addr (b_raddr),
      .rd_data (b_rdata)
   );

   assign req_tready = state_ff == ST_IDLE;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign g_we    = req_tvalid && req_tready && (cnt_ff < CW'(DEPTH));
   assign g_waddr = AW'(cnt_ff);
   assign g_raddr = tap_addr;
   assign b_we    = state_ff == ST_BCMP;
   assign b_waddr = cur_addr;
   assign b_wdata = 34'(lhs_ff) > thr_ff;
   assign b_raddr = (state_ff == ST_DINIT) ? cur_addr : scan_addr;

   // Sequencer and datapath next state.
   always_comb begin
      logic [28:0] sh;
      enable_in = enable_ff;  side_in = side_ff;  ratio_in = ratio_ff;
      base_in = base_ff;      step_in = step_ff;
      state_in = state_ff;    cnt_in = cnt_ff;    bbox_in = bbox_ff;
      r_in = r_ff;  c_in = c_ff;  r2_in = r2_ff;  c2_in = c2_ff;
      ti_in = ti_ff;  tj_in = tj_ff;
      ss_in = ss_ff;  sp5_in = sp5_ff;  sub_in = sub_ff;  nsub_in = nsub_ff;
      sum_in = sum_ff;  p_in = p_ff;  inr_in = inr_ff;
      thr_in = thr_ff;  lhs_in = lhs_ff;  best_in = best_ff;
      count_in = count_ff;  deep_in = deep_ff;
      verd_in = verd_ff;  disp_in = disp_ff;
      rsp_valid_in = rsp_valid_ff;  rsp_data_in = rsp_data_ff;
      sh = {sum_ff, 16'b0};

      // Configuration writes.
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ENABLE:     enable_in = csr_data[0];
            CSR_GLYPH_SIDE: side_in   = csr_data[7:0];
            CSR_MIN_RATIO:  ratio_in  = csr_data;
            CSR_BASE_OFS:   base_in   = csr_data;
            CSR_SMALL_STEP: step_in   = csr_data;
            default: ;
         endcase
      end

      // Result register drains independently.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (cnt_ff < CW'(DEPTH)) cnt_in = cnt_ff + CW'(1);
               if (req_tlast) begin
                  cnt_in   = '0;
                  bbox_in  = req_tdata[16:8];
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            ss_in  = (2*SW)'(s_n) * (2*SW)'(s_n);
            sp5_in = 12'(6'(s_n) + 6'd5) * 12'(6'(s_n) + 6'd5);
            sub_in = 29'(base_ff) * 29'd255 + ((29'(k_val) * 29'(step_ff)) << 8);
            count_in = '0;
            deep_in  = 1'b0;
            disp_in  = 1'b0;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            nsub_in = 34'(n_val) * 34'(sub_ff);
            r_in = '0;  c_in = '0;  ti_in = '0;  tj_in = '0;  sum_in = '0;
            if (!enable_ff) begin
               verd_in  = VERDICT_DISABLED;
               state_in = ST_FINISH;
            end else if (side_ff >= 8'(FONT_SIZE_LIMIT)) begin
               verd_in  = VERDICT_LARGE_FONT;
               state_in = ST_FINISH;
            end else if (26'({bbox_ff, 16'b0}) < 26'(ratio_ff) * 26'(ss_ff)) begin
               verd_in  = VERDICT_SMALL_BBOX;
               state_in = ST_FINISH;
            end else if (side_ff == 8'd0) begin
               state_in = ST_DECIDE;
            end else begin
               state_in = ST_BRD;
            end
         end
         // Box sum: issue one tap read.
         ST_BRD: begin
            inr_in   = rin && cin;
            state_in = ST_BACC;
         end
         ST_BACC: begin
            if (inr_ff) sum_in = sum_ff + 13'(g_rdata);
            if ((SW+1)'(ti_ff) == h_val && (SW+1)'(tj_ff) == h_val) p_in = g_rdata;
            state_in = ST_BRD;
            if (tj_ff == tap_end) begin
               tj_in = '0;
               ti_in = ti_ff + 3'd1;
               if (ti_ff == tap_end) begin
                  ti_in    = '0;
                  state_in = ST_BTHR;
               end
            end else begin
               tj_in = tj_ff + 3'd1;
            end
         end
         // Threshold and scaled pixel for the comparison.
         ST_BTHR: begin
            thr_in   = (34'(sh) > nsub_ff) ? 34'(sh) - nsub_ff : 34'd0;
            lhs_in   = {13'(n_val) * 13'(p_ff), 16'b0};
            state_in = ST_BCMP;
         end
         ST_BCMP: begin
            sum_in   = '0;
            state_in = ST_BRD;
            if (col_end) begin
               c_in = '0;
               r_in = r_ff + SW'(1);
               if (row_end) begin
                  r_in     = '0;
                  state_in = ST_DINIT;
               end
            end else begin
               c_in = c_ff + SW'(1);
            end
         end
         // Distance pass: read own binary value first.
         ST_DINIT: begin
            state_in = ST_DSELF;
         end
         ST_DSELF: begin
            r2_in = '0;
            c2_in = '0;
            if (!b_rdata) begin
               best_in  = '0;
               state_in = ST_DEVAL;
            end else begin
               best_in  = 11'(m_val) * 11'(m_val);
               state_in = ST_DRD;
            end
         end
         ST_DRD: begin
            state_in = ST_DACC;
         end
         ST_DACC: begin
            if (!b_rdata && sq_dist < best_ff) best_in = sq_dist;
            state_in = ST_DRD;
            if (scan_col_end) begin
               c2_in = '0;
               r2_in = r2_ff + SW'(1);
               if (scan_row_end) begin
                  r2_in    = '0;
                  state_in = ST_DEVAL;
               end
            end else begin
               c2_in = c2_ff + SW'(1);
            end
         end
         ST_DEVAL: begin
            if (core && count_ff != 9'd511) count_in = count_ff + 9'd1;
            if (over) deep_in = 1'b1;
            state_in = ST_DINIT;
            if (col_end) begin
               c_in = '0;
               r_in = r_ff + SW'(1);
               if (row_end) begin
                  r_in     = '0;
                  state_in = ST_DECIDE;
               end
            end else begin
               c_in = c_ff + SW'(1);
            end
         end
         ST_DECIDE: begin
            if (side_ff >= 8'd6 && count_ff > {1'b0, side_ff - 8'd6}) begin
               verd_in = VERDICT_CORE_COUNT;
               disp_in = 1'b1;
            end else if (deep_ff) begin
               verd_in = VERDICT_CORE_DEPTH;
               disp_in = 1'b1;
            end else begin
               verd_in = VERDICT_READABLE;
            end
            state_in = ST_FINISH;
         end
         // Hand the result over once the output register is free.
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b0, count_ff, verd_ff, disp_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         enable_ff    <= 1'b1;
         side_ff      <= 8'd10;
         ratio_ff     <= 16'd32768;
         base_ff      <= '0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         enable_ff    <= enable_in;
         side_ff      <= side_in;
         ratio_ff     <= ratio_in;
         base_ff      <= base_in;
         step_ff      <= step_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      bbox_ff  <= bbox_in;
      r_ff     <= r_in;
      c_ff     <= c_in;
      r2_ff    <= r2_in;
      c2_ff    <= c2_in;
      ti_ff    <= ti_in;
      tj_ff    <= tj_in;
      ss_ff    <= ss_in;
      sp5_ff   <= sp5_in;
      sub_ff   <= sub_in;
      nsub_ff  <= nsub_in;
      sum_ff   <= sum_in;
      p_ff     <= p_in;
      inr_ff   <= inr_in;
      thr_ff   <= thr_in;
      lhs_ff   <= lhs_in;
      best_ff  <= best_in;
      count_ff <= count_in;
      deep_ff  <= deep_in;
      verd_ff  <= verd_in;
      disp_ff  <= disp_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== verif/tb_glyph_readability_check_top.sv =====
// Testbench of the glyph readability check: directed and random glyphs, own predictor.
// Depends on grc_pkg and glyph_readability_check_top.
`timescale 1ns / 1ps

module tb_glyph_readability_check_top;
   import grc_pkg::*;

   localparam int SIZE_LIMIT = 20;
   localparam int STORE_N    = (SIZE_LIMIT - 1) * (SIZE_LIMIT - 1);

   typedef struct packed {
      logic [COUNT_W-1:0]   core_count;
      logic [VERDICT_W-1:0] verdict;
      logic                 disposable;
   } verdict_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [23:0]           req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DAT_W-1:0]  csr_data = '0;

   glyph_readability_check_top #(.FONT_SIZE_LIMIT(SIZE_LIMIT)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Register mirror and stores of the predictor.
   logic        m_enable = 1'b1;
   int unsigned m_side = 10;
   longint      m_ratio = 32768;
   longint      m_offset = 0;
   longint      m_step = 0;
   logic [7:0]  pix_mem [STORE_N];
   logic        bin_mem [STORE_N];
   int          dist_mem [STORE_N];
   int          load_pos = 0;
   int          filled = 0;     // high-water mark of written pixel positions
   verdict_type pending_verdicts [$];
   int          errors = 0;
   int          items_sent = 0;
   bit          quiet = 1'b0;
   bit          hold_rsp = 1'b0;

   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
   endtask

   // Binarise against the padded box mean, then take exact squared distances.
   function automatic verdict_type judge_glyph(input int bbox);
      verdict_type v;
      int s, w, h, cnt;
      longint n, k, sub, sum, thr, lhs;
      int best, mm, d;
      bit deep, core, over;
      v = '0;
      s = m_side;
      if (!m_enable) begin
         v.verdict = VERDICT_DISABLED;
         return v;
      end
      if (s >= SIZE_LIMIT) begin
         v.verdict = VERDICT_LARGE_FONT;
         return v;
      end
      if (longint'(bbox) * 65536 < m_ratio * longint'(s * s)) begin
         v.verdict = VERDICT_SMALL_BBOX;
         return v;
      end
      w = (s > 15) ? 5 : 3;
      h = w / 2;
      n = w * w;
      k = (s < 15) ? 15 - s : 0;
      sub = m_offset * 255 + k * m_step * 256;
      for (int r = 0; r < s; r++)
         for (int c = 0; c < s; c++) begin
            sum = 0;
            for (int dr = -h; dr <= h; dr++)
               for (int dc = -h; dc <= h; dc++)
                  if (r + dr >= 0 && r + dr < s && c + dc >= 0 && c + dc < s)
                     sum += pix_mem[(r + dr) * s + c + dc];
            thr = sum * 65536 - n * sub;
            if (thr < 0) thr = 0;
            lhs = n * longint'(pix_mem[r * s + c]) * 65536;
            bin_mem[r * s + c] = (lhs > thr);
         end
      for (int r = 0; r < s; r++)
         for (int c = 0; c < s; c++) begin
            if (!bin_mem[r * s + c]) begin
               dist_mem[r * s + c] = 0;
               continue;
            end
            mm = r + 1;
            if (c + 1 < mm) mm = c + 1;
            if (s - r < mm) mm = s - r;
            if (s - c < mm) mm = s - c;
            best = mm * mm;
            for (int r2 = 0; r2 < s; r2++)
               for (int c2 = 0; c2 < s; c2++)
                  if (!bin_mem[r2 * s + c2]) begin
                     d = (r - r2) * (r - r2) + (c - c2) * (c - c2);
                     if (d < best) best = d;
                  end
            dist_mem[r * s + c] = best;
         end
      cnt = 0;
      deep = 1'b0;
      for (int i = 0; i < s * s; i++) begin
         if (s <= 10) begin
            core = 100 * dist_mem[i] > 361;
            over = 100 * dist_mem[i] > 841;
         end else begin
            core = 25 * dist_mem[i] > s * s;
            over = 25 * dist_mem[i] > (s + 5) * (s + 5);
         end
         if (core) cnt++;
         if (over) deep = 1'b1;
      end
      if (cnt > 511) cnt = 511;
      v.core_count = COUNT_W'(cnt);
      if (s >= 6 && cnt > s - 6) begin
         v.disposable = 1'b1;
         v.verdict = VERDICT_CORE_COUNT;
      end else if (deep) begin
         v.disposable = 1'b1;
         v.verdict = VERDICT_CORE_DEPTH;
      end else begin
         v.verdict = VERDICT_READABLE;
      end
      return v;
   endfunction

   // Store an accepted pixel and, on the last one, queue the expected verdict.
   task automatic absorb_pixel(input logic [7:0] px, input int bbox, input bit last);
      if (load_pos < STORE_N) begin
         pix_mem[load_pos] = px;
         load_pos++;
         if (load_pos > filled) filled = load_pos;
      end
      if (last) begin
         load_pos = 0;
         pending_verdicts.push_back(judge_glyph(bbox));
      end
   endtask

   // Offer one pixel transaction, at times with a random gap ahead of it.
   task automatic send_pixel(input logic [7:0] px, input int bbox, input bit last);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, bbox[8:0], px};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      absorb_pixel(px, bbox, last);
   endtask

   // Pixel of a glyph pattern: noise, a solid square, all ink, all paper or a checkerboard.
   function automatic logic [7:0] pattern_pixel(input int mode, input int idx, input int s);
      int r, c;
      r = (s > 0) ? idx / s : 0;
      c = (s > 0) ? idx % s : 0;
      case (mode)
         0: return 8'($urandom_range(0, 255));
         1: return (r >= 1 && c >= 1 && r < s - 1 && c < s - 1) ? 8'd255 : 8'd0;
         2: return 8'd255;
         3: return 8'd0;
         default: return (r + c) % 2 ? 8'd255 : 8'd0;
      endcase
   endfunction

   // Send one glyph of len pixels; short glyphs only over positions already written.
   task automatic send_glyph(input int len, input int mode, input int bbox);
      int s2;
      s2 = m_side * m_side;
      if (s2 > STORE_N) s2 = STORE_N;
      if (len < s2 && s2 > filled) len = s2;
      if (len < 1) len = 1;
      for (int i = 0; i < len; i++)
         send_pixel(pattern_pixel(mode, i, m_side), bbox, i == len - 1);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Register write: first waits for the block to drain.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[15:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_ENABLE:     m_enable = value[0];
         CSR_GLYPH_SIDE: m_side   = value[7:0];
         CSR_MIN_RATIO:  m_ratio  = value[15:0];
         CSR_BASE_OFS:   m_offset = value[15:0];
         CSR_SMALL_STEP: m_step   = value[15:0];
         default: ;
      endcase
   endtask

   // Result side: random stalls, a long hold-off on request.
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            for (int cyc = 0; cyc < 400; cyc++) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Compare each result transaction with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         verdict_type got, want;
         got = rsp_tdata[12:0];
         if (pending_verdicts.size() == 0) begin
            report_mismatch("unexpected result, verdict", got.verdict, -1);
         end else begin
            want = pending_verdicts.pop_front();
            if (got.disposable !== want.disposable)
               report_mismatch("disposable", got.disposable, want.disposable);
            if (got.verdict !== want.verdict)
               report_mismatch("verdict", got.verdict, want.verdict);
            if (got.core_count !== want.core_count)
               report_mismatch("core_count", got.core_count, want.core_count);
         end
      end
   end

   task automatic test_bypass_paths;
      write_reg(CSR_ENABLE, 0);
      send_glyph(1, 0, 361);
      write_reg(CSR_ENABLE, 1);
      write_reg(CSR_GLYPH_SIDE, SIZE_LIMIT);
      send_glyph(1, 2, 0);
      write_reg(CSR_GLYPH_SIDE, 255);
      send_glyph(2, 0, 256);
      write_reg(CSR_GLYPH_SIDE, 0);
      send_glyph(1, 3, 0);
   endtask

   task automatic test_small_glyphs;
      write_reg(CSR_GLYPH_SIDE, 3);
      write_reg(CSR_MIN_RATIO, 65535);
      send_glyph(9, 2, 0);
      write_reg(CSR_MIN_RATIO, 0);
      write_reg(CSR_BASE_OFS, 65535);
      write_reg(CSR_SMALL_STEP, 65535);
      send_glyph(9, 0, 511);
      write_reg(CSR_BASE_OFS, 0);
      write_reg(CSR_SMALL_STEP, 0);
      write_reg(CSR_GLYPH_SIDE, 4);
      send_glyph(16, 2, 16);
   endtask

   task automatic test_core_checks;
      write_reg(CSR_GLYPH_SIDE, 6);
      send_glyph(36, 2, 36);
      write_reg(CSR_GLYPH_SIDE, 10);
      send_glyph(100, 1, 100);
      write_reg(CSR_GLYPH_SIDE, 19);
      send_glyph(361, 2, 361);
      write_reg(CSR_GLYPH_SIDE, 16);
      send_glyph(256, 4, 300);
   endtask

   // Hold the result side while the next glyphs keep coming.
   task automatic test_backpressure;
      write_reg(CSR_GLYPH_SIDE, 3);
      write_reg(CSR_MIN_RATIO, 0);
      hold_rsp = 1'b1;
      for (int g = 0; g < 4; g++) send_glyph(9, g % 2, 9);
      drain();
   endtask

   task automatic test_random_glyphs(input int target);
      int len, s2, mode, bbox, pick;
      while (items_sent < target) begin
         if (items_sent > target - 250) quiet = 1'b1;
         pick = $urandom_range(0, 9);
         if (pick == 0) write_reg(CSR_ENABLE, $urandom_range(0, 5) != 0);
         if (pick <= 3) begin
            pick = $urandom_range(0, 19);
            if (pick < 15) write_reg(CSR_GLYPH_SIDE, $urandom_range(2, 8));
            else if (pick < 18) write_reg(CSR_GLYPH_SIDE, $urandom_range(9, 12));
            else if (pick < 19) write_reg(CSR_GLYPH_SIDE, $urandom_range(0, 1));
            else write_reg(CSR_GLYPH_SIDE, $urandom_range(20, 255));
         end
         if (pick == 4) write_reg(CSR_MIN_RATIO, $urandom_range(0, 65535));
         if (pick == 5) write_reg(CSR_MIN_RATIO, $urandom_range(0, 4096));
         if (pick == 6) write_reg(CSR_BASE_OFS,
                                  $urandom_range(0, 1) ? $urandom_range(0, 8192)
                                                       : $urandom_range(0, 65535));
         if (pick == 7) write_reg(CSR_SMALL_STEP,
                                  $urandom_range(0, 1) ? $urandom_range(0, 2048)
                                                       : $urandom_range(0, 65535));
         s2 = m_side * m_side;
         if (s2 > STORE_N) s2 = 4;
         pick = $urandom_range(0, 19);
         if (pick < 16) len = s2;
         else if (pick < 18) len = $urandom_range(1, s2 + 1);
         else if (pick < 19) len = s2 + $urandom_range(1, 5);
         else len = STORE_N + $urandom_range(1, 6);
         mode = $urandom_range(0, 4);
         bbox = $urandom_range(0, 1) ? $urandom_range(0, 361) : $urandom_range(0, 511);
         send_glyph(len, mode, bbox);
      end
      drain();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_bypass_paths();
      test_small_glyphs();
      test_core_checks();
      test_backpressure();
      test_random_glyphs(1650);
      repeat (50) @(posedge clock);
      if (errors == 0 && pending_verdicts.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #40ms;
      $display("Some tests failed");
      $finish;
   end

endmodule
